[hw/rtl/ais_pkg.sv]
// package for the ascending integer sorter
// shared constants, the controller state type and the per-cell control word
package ais_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;

    typedef enum logic {
        ST_COLLECT,
        ST_DRAIN
    } state_t;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic shift_out;
    } cell_ctrl_t;

endpackage

[hw/rtl/ais_cell.sv]
// one cell of the sorting chain: holds one integer and its occupied bit
// depends on ais_pkg
module ais_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ais_pkg::cell_ctrl_t                 ctrl,
    input  logic signed [ais_pkg::DATA_W-1:0]   new_value,
    input  logic signed [ais_pkg::DATA_W-1:0]   left_value,
    input  logic                                left_lt,
    input  logic                                left_occ,
    input  logic signed [ais_pkg::DATA_W-1:0]   right_value,
    input  logic                                right_occ,
    output logic signed [ais_pkg::DATA_W-1:0]   value,
    output logic                                lt,
    output logic                                occ
);
    import ais_pkg::*;

    logic signed [DATA_W-1:0] value_reg, value_next;
    logic                     occ_reg, occ_next;

    // new word belongs at or before this cell
    assign lt = !occ_reg || (new_value < value_reg);

    // insert shifts the tail right, drain shifts everything left
    always_comb begin
        value_next = value_reg;
        occ_next   = occ_reg;
        if (ctrl.shift_out) begin
            value_next = right_value;
            occ_next   = right_occ;
        end else if (ctrl.insert) begin
            if (lt) begin
                value_next = left_lt ? left_value : new_value;
            end
            occ_next = occ_reg | left_occ;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign occ   = occ_reg;

endmodule

[hw/rtl/ascending_integer_sort.sv]
// top level of the ascending integer sorter
// depends on ais_pkg and ais_cell
//
// Usage:
//  s_ channel takes one signed 32-bit word per handshake; s_last closes the set.
//  Words are inserted into a chain of CAPACITY cells kept in ascending order,
//  one word per cycle, each cell comparing the new word with its own entry.
//  After the last word the chain drains from its head, one word per cycle on
//  the m_ channel, smallest first; m_end_of_run marks the largest word.
//  Words beyond CAPACITY are dropped and m_overflow is high on every word
//  of that set.
//  The first sorted word is valid in the cycle after the last word is
//  accepted. The single shared chain either loads or drains, so a new set
//  is not accepted until the previous set has drained.
//  s_ready is low while a set drains; the next set is accepted the cycle
//  after the final word is taken.
//  A stall on m_ready holds the chain and the presented word unchanged.
//  Reset (aresetn low, synchronous) empties the chain and clears the
//  overflow flag; no clearing pass is needed.
module ascending_integer_sort (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [ais_pkg::DATA_W-1:0]  s_value,
    input  logic                               s_last,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [ais_pkg::DATA_W-1:0]  m_sorted_value,
    output logic                               m_end_of_run,
    output logic                               m_overflow
);
    import ais_pkg::*;

    state_t     state_reg, state_next;
    logic       dropped_reg, dropped_next;
    cell_ctrl_t ctrl;
    logic       in_fire, out_fire, room;

    // chain wires: index 0 is the left boundary, CAPACITY+1 the right one
    logic signed [DATA_W-1:0] value_w [0:CAPACITY+1];
    logic                     occ_w   [0:CAPACITY+1];
    logic                     lt_w    [0:CAPACITY];

    assign value_w[0]          = '0;
    assign occ_w[0]            = 1'b1;
    assign lt_w[0]             = 1'b0;
    assign value_w[CAPACITY+1] = '0;
    assign occ_w[CAPACITY+1]   = 1'b0;

    // row of cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        ais_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .new_value   (s_value),
            .left_value  (value_w[i]),
            .left_lt     (lt_w[i]),
            .left_occ    (occ_w[i]),
            .right_value (value_w[i+2]),
            .right_occ   (occ_w[i+2]),
            .value       (value_w[i+1]),
            .lt          (lt_w[i+1]),
            .occ         (occ_w[i+1])
        );
    end

    // handshakes and chain control
    assign in_fire       = s_valid && s_ready;
    assign out_fire      = m_valid && m_ready;
    assign room          = !occ_w[CAPACITY];
    assign ctrl.insert    = in_fire && room;
    assign ctrl.shift_out = out_fire;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT: begin
                if (in_fire && s_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_fire && m_end_of_run) begin
                    state_next = ST_COLLECT;
                end
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    // outputs of the controller
    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ST_COLLECT: s_ready = 1'b1;
            ST_DRAIN:   m_valid = 1'b1;
            default: begin
                s_ready = 1'b0;
                m_valid = 1'b0;
            end
        endcase
    end

    // overflow flag for the current set
    always_comb begin
        dropped_next = dropped_reg;
        if (in_fire && !room) begin
            dropped_next = 1'b1;
        end else if (out_fire && m_end_of_run) begin
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_COLLECT;
            dropped_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dropped_reg <= dropped_next;
        end
    end

    // head of the chain is the outgoing word
    assign m_sorted_value = value_w[1];
    assign m_end_of_run   = !occ_w[2];
    assign m_overflow     = dropped_reg;

endmodule

[dv/testbench.sv]
// testbench for ascending_integer_sort: random and directed sets of signed words
// depends on ais_pkg and the ascending_integer_sort top level
// a sorted-insert predictor builds the expected runs, a monitor checks each word
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [ais_pkg::DATA_W-1:0] word_t;

    typedef struct {
        word_t value;
        logic  last;
    } in_word_t;

    typedef struct {
        word_t value;
        logic  end_of_run;
        logic  overflow;
    } out_word_t;

    localparam word_t W_MAX       = 32'sh7FFF_FFFF;
    localparam word_t W_MIN       = 32'sh8000_0000;
    localparam int    CYCLE_LIMIT = 200_000;
    localparam int    SETTLE      = 20;

    logic  aclk           = 1'b0;
    logic  aresetn        = 1'b0;
    logic  s_valid        = 1'b0;
    logic  s_ready;
    word_t s_value        = '0;
    logic  s_last         = 1'b0;
    logic  m_valid;
    logic  m_ready        = 1'b0;
    word_t m_sorted_value;
    logic  m_end_of_run;
    logic  m_overflow;

    // words waiting to be sent, the set being collected, and runs still due
    in_word_t  words_to_send[$];
    word_t     held_sorted[$];
    logic      set_dropped = 1'b0;
    out_word_t sorted_due[$];
    in_word_t  next_word;

    int gap_pct    = 38;
    int stall_pct  = 38;
    int mismatches = 0;
    int cycles     = 0;

    ascending_integer_sort dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sorted_value(m_sorted_value),
        .m_end_of_run  (m_end_of_run),
        .m_overflow    (m_overflow)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    task automatic note_mismatch(string what);
        mismatches++;
        $display("[%0d] sorted word mismatch: %s", cycles, what);
    endtask

    // keep the held set in ascending order; a last word releases the whole run
    function automatic void absorb_word(word_t v, logic is_last);
        int        pos;
        out_word_t w;
        if (held_sorted.size() < ais_pkg::CAPACITY) begin
            pos = 0;
            while (pos < held_sorted.size() && held_sorted[pos] <= v) pos++;
            held_sorted.insert(pos, v);
        end else begin
            set_dropped = 1'b1;
        end
        if (is_last) begin
            foreach (held_sorted[k]) begin
                w.value      = held_sorted[k];
                w.end_of_run = (k == held_sorted.size() - 1);
                w.overflow   = set_dropped;
                sorted_due.push_back(w);
            end
            held_sorted.delete();
            set_dropped = 1'b0;
        end
    endfunction

    task automatic check_word();
        out_word_t want;
        if (sorted_due.size() == 0) begin
            note_mismatch($sformatf("word %0d arrived with nothing due", m_sorted_value));
        end else begin
            want = sorted_due.pop_front();
            if (m_sorted_value !== want.value || m_end_of_run !== want.end_of_run ||
                m_overflow !== want.overflow) begin
                note_mismatch($sformatf("got %0d/%b/%b, want %0d/%b/%b",
                    m_sorted_value, m_end_of_run, m_overflow,
                    want.value, want.end_of_run, want.overflow));
            end
        end
    endtask

    // driver: one word per handshake, random gaps between words
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_word(s_value, s_last);
            end
            if (!s_valid || s_ready) begin
                if (words_to_send.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    next_word = words_to_send.pop_front();
                    s_valid <= 1'b1;
                    s_value <= next_word.value;
                    s_last  <= next_word.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each accepted word, random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_word();
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("ascending_integer_sort: mismatch");
            $finish;
        end
    end

    task automatic push_word(word_t v, logic is_last);
        in_word_t w;
        w.value = v;
        w.last  = is_last;
        words_to_send.push_back(w);
    endtask

    // mix of extremes, small values that collide, and full-range values
    function automatic word_t pick_value();
        case ($urandom_range(9))
            0:       return W_MAX;
            1:       return W_MIN;
            2, 3:    return word_t'($urandom_range(6)) - 3;
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic queue_set(int n);
        for (int i = 0; i < n; i++) begin
            push_word(pick_value(), i == n - 1);
        end
    endtask

    // mostly short sets, now and then a longer one; the final set is cut to fit
    task automatic queue_random_sets(int target);
        int n;
        int sent;
        sent = 0;
        while (sent < target) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            if (n > target - sent) n = target - sent;
            queue_set(n);
            sent += n;
        end
    endtask

    // sender holds off until every queued word is taken and every run is out
    task automatic wait_quiet();
        do @(negedge aclk);
        while (words_to_send.size() != 0 || s_valid || sorted_due.size() != 0);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // single-word sets at both extremes
        push_word(W_MAX, 1'b1);
        push_word(W_MIN, 1'b1);
        // extremes and neighbors of zero mixed
        push_word(0, 1'b0);
        push_word(-1, 1'b0);
        push_word(1, 1'b0);
        push_word(W_MAX, 1'b0);
        push_word(W_MIN, 1'b0);
        push_word(-2, 1'b0);
        push_word(2, 1'b1);
        // equal words side by side
        push_word(5, 1'b0);
        push_word(5, 1'b0);
        push_word(-5, 1'b0);
        push_word(5, 1'b1);
        push_word(W_MAX, 1'b0);
        push_word(W_MIN, 1'b0);
        push_word(W_MAX, 1'b0);
        push_word(W_MIN, 1'b1);
        // descending input
        push_word(3, 1'b0);
        push_word(2, 1'b0);
        push_word(1, 1'b0);
        push_word(0, 1'b1);
        wait_quiet();

        // capacity edge: chain fills, one word dropped, then the last word dropped
        queue_set(ais_pkg::CAPACITY + 2);
        queue_set(1);
        wait_quiet();

        queue_random_sets(11);
        wait_quiet();

        // stretch with no gaps and no stalls
        gap_pct   = 0;
        stall_pct = 0;
        queue_random_sets(20);
        wait_quiet();

        gap_pct   = 38;
        stall_pct = 38;
        queue_random_sets(11);
        wait_quiet();

        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0) begin
            $display("ascending_integer_sort: match");
        end else begin
            $display("ascending_integer_sort: mismatch");
        end
        $finish;
    end

endmodule
